FILE: design/offset_packed_column_store_defines.svh
// assertion helpers shared by the offset store
`ifndef OFFSET_PACKED_COLUMN_STORE_DEFINES_SVH
`define OFFSET_PACKED_COLUMN_STORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define OCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("offset store check failed");

// next-cycle implication, disabled while reset is low
`define OCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("offset store check failed");

`endif

FILE: design/ocs_pkg.sv
`default_nettype none

package ocs_pkg;

    localparam int OFFSET_BITS = 8;
    localparam int DEPTH       = 1024;
    localparam int VALUE_W     = 32;
    localparam int BASE_W      = 34;
    localparam int DIFF_W      = 35;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CELL_BITS   = 3;
    localparam int NUM_CELLS   = 1 << CELL_BITS;
    localparam int ROW_W       = IDX_W - CELL_BITS;
    localparam int BANK_DEPTH  = DEPTH >> CELL_BITS;
    localparam int OFS_MAX     = (1 << OFFSET_BITS) - 1;
    localparam int SPARE       = (OFS_MAX + 1) >> 3;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_SWEEP
    } t_op;

    // command travelling down the cell chain
    typedef struct packed {
        logic                   valid;
        t_op                    op;
        logic [CELL_BITS-1:0]   slot;
        logic [ROW_W-1:0]       row;
        logic [OFFSET_BITS-1:0] data;
    } t_cmd;

    // read data travelling behind the command, leaving each cell in the cycle after it
    typedef struct packed {
        logic                   valid;
        logic [OFFSET_BITS-1:0] data;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALC,
        S_DEC,
        S_ROOM,
        S_SWEEP,
        S_GAP,
        S_PUSHW,
        S_WAIT_RD,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: design/offset_packed_column_store.sv
// offset packed column store
// signed 32-bit values kept as 8-bit offsets from one shared base.
// input channel: i_in_valid / o_in_stall carries mode, value and index;
// mode 0 pushes value, mode 1 reads the entry at index.
// output channel: o_out_valid / i_out_stall carries accepted, read_value
// and rebased, exactly one result transfer for every input transfer.
// one item is worked at a time; o_in_stall is low only while idle.
// the offsets live in a chain of 8 cells, each holding 128 entries
// (entry i sits in cell i mod 8); commands walk the chain one cell per cycle.
// a read waits for its data to come out of the far end of the chain;
// a read past the count does not enter the chain. a push below the base
// that still fits first sweeps the cells: every row holding an entry is
// read, raised by the shift and written back, one row per cycle.
// a stalled result holds its payload and blocks the next input transfer.
// synchronous active-low reset empties the store: count, base and largest
// offset go to zero; offset contents are not cleared and need no sweep.
`default_nettype none
`include "offset_packed_column_store_defines.svh"

module offset_packed_column_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_mode,
    input  logic signed [31:0]        i_value,
    input  logic [9:0]                i_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic signed [31:0]        o_read_value,
    output logic                      o_rebased
);
    import ocs_pkg::*;

    // control state
    t_state                 r_state,   n_state;
    logic [BASE_W-1:0]      r_base,    n_base;
    logic [OFFSET_BITS-1:0] r_largest, n_largest;
    logic [CNT_W-1:0]       r_count,   n_count;
    t_cmd                   r_cmd,     n_cmd;

    // working registers of the current item
    logic                   r_mode,       n_mode;
    logic [VALUE_W-1:0]     r_value,      n_value;
    logic [IDX_W-1:0]       r_index,      n_index;
    logic [DIFF_W-1:0]      r_diff,       n_diff;
    logic [DIFF_W-1:0]      r_room,       n_room;
    logic [OFFSET_BITS-1:0] r_shift,      n_shift;
    logic [OFFSET_BITS-1:0] r_newofs,     n_newofs;
    logic [ROW_W-1:0]       r_row,        n_row;
    logic                   r_accepted,   n_accepted;
    logic [VALUE_W-1:0]     r_read_value, n_read_value;
    logic                   r_rebased,    n_rebased;

    // cell chain taps
    t_cmd w_cmd [NUM_CELLS+1];
    t_res w_res [NUM_CELLS+1];

    logic [DIFF_W-1:0]      w_value35;
    logic [BASE_W-1:0]      w_value34;
    logic [DIFF_W-1:0]      w_base35;
    logic [ROW_W-1:0]       w_last_row;
    logic [OFFSET_BITS-1:0] w_pick;
    logic [DIFF_W-1:0]      w_shift_full;
    logic [CNT_W-1:0]       w_count_m1;

    assign w_value35 = {{(DIFF_W - VALUE_W){r_value[VALUE_W-1]}}, r_value};
    assign w_value34 = {{(BASE_W - VALUE_W){r_value[VALUE_W-1]}}, r_value};
    assign w_base35  = {r_base[BASE_W-1], r_base};

    // last row of the cells that holds a stored entry
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_last_row = w_count_m1[IDX_W-1:CELL_BITS];

    // extra headroom kept below the new base: min(room, spare)
    assign w_pick = (r_room < DIFF_W'(SPARE)) ? r_room[OFFSET_BITS-1:0]
                                              : OFFSET_BITS'(SPARE);
    // shift = shortfall + pick, the diff being negative here
    assign w_shift_full = DIFF_W'(w_pick) - r_diff;

    assign w_cmd[0] = r_cmd;
    assign w_res[0] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        ocs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .i_res   (w_res[g]),
            .o_cmd   (w_cmd[g+1]),
            .o_res   (w_res[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= '0;
            r_largest <= '0;
            r_count   <= '0;
            r_cmd     <= '0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_largest <= n_largest;
            r_count   <= n_count;
            r_cmd     <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_index      <= n_index;
        r_diff       <= n_diff;
        r_room       <= n_room;
        r_shift      <= n_shift;
        r_newofs     <= n_newofs;
        r_row        <= n_row;
        r_accepted   <= n_accepted;
        r_read_value <= n_read_value;
        r_rebased    <= n_rebased;
    end

    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_largest    = r_largest;
        n_count      = r_count;
        n_cmd        = '0;
        n_mode       = r_mode;
        n_value      = r_value;
        n_index      = r_index;
        n_diff       = r_diff;
        n_room       = r_room;
        n_shift      = r_shift;
        n_newofs     = r_newofs;
        n_row        = r_row;
        n_accepted   = r_accepted;
        n_read_value = r_read_value;
        n_rebased    = r_rebased;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode       = i_mode;
                    n_value      = i_value;
                    n_index      = i_index;
                    n_accepted   = 1'b0;
                    n_read_value = '0;
                    n_rebased    = 1'b0;
                    n_state      = S_CALC;
                end
            end
            S_CALC: begin
                if (r_mode == MODE_READ) begin
                    if (CNT_W'(r_index) < r_count) begin
                        n_cmd.valid = 1'b1;
                        n_cmd.op    = OP_READ;
                        n_cmd.slot  = r_index[CELL_BITS-1:0];
                        n_cmd.row   = r_index[IDX_W-1:CELL_BITS];
                        n_state     = S_WAIT_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_count == CNT_W'(DEPTH)) begin
                    // store full
                    n_state = S_OUT;
                end else if (r_count == '0) begin
                    // first push sets the base
                    n_base   = w_value34 - BASE_W'(SPARE);
                    n_newofs = OFFSET_BITS'(SPARE);
                    n_state  = S_PUSHW;
                end else begin
                    n_diff  = w_value35 - w_base35;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_diff[DIFF_W-1]) begin
                    if (r_diff[DIFF_W-1:OFFSET_BITS] != '0) begin
                        // offset too large
                        n_state = S_OUT;
                    end else begin
                        n_newofs = r_diff[OFFSET_BITS-1:0];
                        n_state  = S_PUSHW;
                    end
                end else begin
                    n_room  = DIFF_W'(OFS_MAX) - DIFF_W'(r_largest) + r_diff;
                    n_state = S_ROOM;
                end
            end
            S_ROOM: begin
                if (r_room[DIFF_W-1]) begin
                    // no headroom below the base
                    n_state = S_OUT;
                end else begin
                    n_newofs  = w_pick;
                    n_shift   = w_shift_full[OFFSET_BITS-1:0];
                    n_row     = '0;
                    n_rebased = 1'b1;
                    n_state   = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_cmd.valid = 1'b1;
                n_cmd.op    = OP_SWEEP;
                n_cmd.row   = r_row;
                n_cmd.data  = r_shift;
                if (r_row == w_last_row) begin
                    n_state = S_GAP;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_GAP: begin
                // bubble lets the last write-back land before the push write
                n_base    = r_base - BASE_W'(r_shift);
                n_largest = r_largest + r_shift;
                n_state   = S_PUSHW;
            end
            S_PUSHW: begin
                n_cmd.valid = 1'b1;
                n_cmd.op    = OP_WRITE;
                n_cmd.slot  = r_count[CELL_BITS-1:0];
                n_cmd.row   = r_count[IDX_W-1:CELL_BITS];
                n_cmd.data  = r_newofs;
                n_count     = r_count + CNT_W'(1);
                if (r_newofs > r_largest) begin
                    n_largest = r_newofs;
                end
                n_accepted  = 1'b1;
                n_state     = S_OUT;
            end
            S_WAIT_RD: begin
                if (w_res[NUM_CELLS].valid) begin
                    n_read_value = r_base[VALUE_W-1:0] + VALUE_W'(w_res[NUM_CELLS].data);
                    n_accepted   = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_accepted   = r_accepted;
    assign o_read_value = r_read_value;
    assign o_rebased    = r_rebased;

    // read data leaves the chain only while a read waits for it
    `OCS_ASSERT_IMPL(a_res_only_waiting, i_clk, i_rst_n,
        w_res[NUM_CELLS].valid, r_state == S_WAIT_RD)
    // a push never writes into a full store
    `OCS_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n,
        r_state == S_PUSHW, r_count != CNT_W'(DEPTH))
    // an empty store tracks no offset
    `OCS_ASSERT_IMPL(a_empty_no_largest, i_clk, i_rst_n,
        r_count == '0, r_largest == '0)
    // the largest offset never shrinks once entries exist
    `OCS_ASSERT_NEXT(a_largest_grows, i_clk, i_rst_n,
        r_count != '0, r_largest >= $past(r_largest))

endmodule

`default_nettype wire

FILE: design/ocs_cell.sv
`default_nettype none

module ocs_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ocs_pkg::t_cmd i_cmd,
    input  ocs_pkg::t_res i_res,
    output ocs_pkg::t_cmd o_cmd,
    output ocs_pkg::t_res o_res
);
    import ocs_pkg::*;

    logic [OFFSET_BITS-1:0] r_mem [BANK_DEPTH];
    logic [OFFSET_BITS-1:0] r_rd;
    logic [OFFSET_BITS-1:0] r_shift;
    logic [ROW_W-1:0]       r_waddr;
    logic                   r_wpend;
    logic                   r_hit;
    t_cmd                   r_cmd, n_cmd;
    t_res                   r_res, n_res;

    logic w_sweep;
    logic w_hit_rd;
    logic w_hit_wr;

    // sweeps hit every cell, reads and writes only the addressed one
    assign w_sweep  = i_cmd.valid && (i_cmd.op == OP_SWEEP);
    assign w_hit_rd = i_cmd.valid && (i_cmd.op == OP_READ) && (i_cmd.slot == '0);
    assign w_hit_wr = i_cmd.valid && (i_cmd.op == OP_WRITE) && (i_cmd.slot == '0);

    always_comb begin
        n_cmd       = i_cmd;
        n_cmd.slot  = i_cmd.slot - CELL_BITS'(1);
        n_res.valid = i_res.valid | r_hit;
        n_res.data  = r_hit ? r_rd : i_res.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= '0;
            r_res   <= '0;
            r_hit   <= 1'b0;
            r_wpend <= 1'b0;
        end else begin
            r_cmd   <= n_cmd;
            r_hit   <= w_hit_rd;
            r_wpend <= w_sweep;
            r_res   <= n_res;
        end
    end

    // bank storage: read-modify-write for sweeps, plain write for pushes
    always_ff @(posedge i_clk) begin
        if (w_sweep || w_hit_rd) begin
            r_rd <= r_mem[i_cmd.row];
        end
        if (w_sweep) begin
            r_waddr <= i_cmd.row;
            r_shift <= i_cmd.data;
        end
        if (r_wpend) begin
            r_mem[r_waddr] <= r_rd + r_shift;
        end else if (w_hit_wr) begin
            r_mem[i_cmd.row] <= i_cmd.data;
        end
    end

    assign o_cmd = r_cmd;
    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: verif/tb_offset_packed_column_store.sv
`timescale 1ns / 100ps

module tb_offset_packed_column_store;
    import ocs_pkg::*;

    // run shape
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1530;
    localparam int FULL_TAIL    = 16;     // pushes refused on a full store before stopping
    localparam int DRAIN_LIMIT  = 200000; // cycles allowed for outstanding results
    localparam int TAIL_CYCLES  = 200;    // covers a rebase sweep of a full store
    localparam int DIR_ROWS     = 18;

    // one result transfer
    typedef struct {
        logic               accepted;
        logic signed [31:0] read_value;
        logic               rebased;
    } t_store_result;

    // one row of the directed table; known holds the result when typed is set
    typedef struct {
        logic               mode;
        logic signed [31:0] value;
        logic [9:0]         index;
        bit                 typed;
        t_store_result      known;
    } t_dir_row;

    // block ports
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               i_mode      = MODE_PUSH;
    logic signed [31:0] i_value     = '0;
    logic [9:0]         i_index     = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_accepted;
    logic signed [31:0] o_read_value;
    logic               o_rebased;

    // predicted contents of the store, starting from the reset state
    logic [OFFSET_BITS-1:0] stored_offsets [DEPTH];
    int                     store_count   = 0;
    longint                 store_base    = 0;
    longint                 store_largest = 0;

    // results still to arrive, oldest first
    t_store_result pending_results [$];

    // idling rates in percent, switched per phase
    int send_idle_pct = 37;
    int recv_idle_pct = 51;

    // bookkeeping
    int fail_count    = 0;
    int transfers     = 0;
    int stored_pushes = 0;
    int rebase_count  = 0;
    int good_reads    = 0;

    // directed table: empty store, first push, both extremes of value,
    // offset just too large, rebase, no headroom, reads past the count
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{MODE_READ, 32'sd0,          10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd1000,       10'd0,    1'b1, '{1'b1, 32'sd0,    1'b0}},
        '{MODE_READ, 32'sd0,          10'd0,    1'b1, '{1'b1, 32'sd1000, 1'b0}},
        '{MODE_READ, 32'sd0,          10'd1,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_READ, 32'sd0,          10'd1023, 1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sh7FFFFFFF,   10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sh80000000,   10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd968,        10'd0,    1'b0, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd1100,       10'd0,    1'b0, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd1224,       10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd960,        10'd0,    1'b0, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_READ, 32'sd0,          10'd0,    1'b1, '{1'b1, 32'sd1000, 1'b0}},
        '{MODE_READ, 32'sd0,          10'd3,    1'b1, '{1'b1, 32'sd960,  1'b0}},
        '{MODE_READ, 32'sd0,          10'd4,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd1184,       10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, 32'sd844,        10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_PUSH, -32'sd1,         10'd0,    1'b1, '{1'b0, 32'sd0,    1'b0}},
        '{MODE_READ, 32'sd0,          10'h2AA,  1'b1, '{1'b0, 32'sd0,    1'b0}}
    };

    offset_packed_column_store i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_index      (i_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_read_value (o_read_value),
        .o_rebased    (o_rebased)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // appends one expected result behind the ones still outstanding
    function automatic void queue_result(input t_store_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // applies one push or read to the predicted store and returns its result
    function automatic t_store_result apply_store_op(input logic m,
                                                     input logic signed [31:0] v,
                                                     input logic [9:0] idx);
        t_store_result r;
        longint        n;
        longint        room;
        longint        shift;
        longint        ofs;
        bit            ok;
        r.accepted   = 1'b0;
        r.read_value = '0;
        r.rebased    = 1'b0;
        n = v;
        if (m == MODE_READ) begin
            // reads past the count give nothing
            if (int'(idx) < store_count) begin
                r.accepted   = 1'b1;
                r.read_value = 32'(store_base + longint'(stored_offsets[idx]));
                good_reads++;
            end
        end else if (store_count >= DEPTH) begin
            // store full: push refused, nothing changes
        end else if (store_count == 0) begin
            // first push leaves spare room below the value
            store_base        = n - SPARE;
            stored_offsets[0] = OFFSET_BITS'(SPARE);
            store_largest     = SPARE;
            store_count       = 1;
            r.accepted        = 1'b1;
            stored_pushes++;
        end else begin
            ok = 1'b1;
            if (n < store_base) begin
                // value below the base: lower the base if the largest offset still fits
                room = OFS_MAX - (store_base + store_largest - n);
                if (room < 0) begin
                    ok = 1'b0;
                end else begin
                    shift = store_base - n + ((room < SPARE) ? room : SPARE);
                    store_base    -= shift;
                    store_largest += shift;
                    for (int i = 0; i < store_count; i++)
                        stored_offsets[i] += shift[OFFSET_BITS-1:0];
                    r.rebased = 1'b1;
                    rebase_count++;
                end
            end else if (n - store_base > OFS_MAX) begin
                ok = 1'b0;
            end
            if (ok) begin
                ofs = n - store_base;
                stored_offsets[store_count] = ofs[OFFSET_BITS-1:0];
                store_count++;
                if (ofs > store_largest)
                    store_largest = ofs;
                r.accepted = 1'b1;
                stored_pushes++;
            end
        end
        return r;
    endfunction

    // one input transfer with a random lead-in gap, then the predicted result
    task automatic transfer_item(input logic m, input logic signed [31:0] v,
                                 input logic [9:0] idx, output t_store_result predicted);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_value    <= v;
        i_index    <= idx;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        // accepted at this edge; valid stays high unless the next call idles
        predicted = apply_store_op(m, v, idx);
        transfers++;
    endtask

    // result side: compare every result transfer, then pick the next stall
    always @(posedge i_clk) begin : result_check
        t_store_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no result outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    fail_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value, o_read_value);
                    fail_count++;
                end
                if (o_rebased !== want.rebased) begin
                    $error("rebased: expected %0d, got %0d", want.rebased, o_rebased);
                    fail_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial begin : stimulus
        t_store_result predicted;
        int            n;
        int            sel;
        int            full_refusals;
        int            drain;
        logic          m;
        logic [31:0]   v;
        logic [9:0]    idx;
        longint        pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, typed results where they are obvious
        foreach (directed_rows[r]) begin
            transfer_item(directed_rows[r].mode, directed_rows[r].value,
                          directed_rows[r].index, predicted);
            if (directed_rows[r].typed)
                queue_result(directed_rows[r].known);
            else
                queue_result(predicted);
        end

        // random part: mostly pushes close to the base so the store fills up,
        // some below the base to force rebases, reads in and past range, noise
        n = 0;
        full_refusals = 0;
        while (n < RANDOM_ITEMS || full_refusals < FULL_TAIL) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 37;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel  = $urandom_range(0, 99);
            m    = MODE_PUSH;
            idx  = 10'($urandom);
            pick = 0;
            if (sel < 66) begin
                // inside the current offset span
                pick = store_base + longint'($urandom_range(0, int'(store_largest)));
            end else if (sel < 69) begin
                // widen the span, now and then one past the maximum
                pick = store_base + longint'($urandom_range(int'(store_largest), OFS_MAX + 1));
            end else if (sel < 77) begin
                // below the base, up to one past the headroom
                if (store_largest < OFS_MAX)
                    pick = store_base
                         - longint'($urandom_range(1, OFS_MAX - int'(store_largest) + 1));
                else
                    pick = store_base - longint'($urandom_range(1, 8));
            end else if (sel < 90) begin
                m   = MODE_READ;
                idx = (store_count > 0) ? 10'($urandom_range(0, store_count - 1)) : 10'd0;
            end else if (sel < 94) begin
                m   = MODE_READ;
                if (store_count < DEPTH)
                    idx = 10'($urandom_range(store_count, DEPTH - 1));
            end else begin
                // raw noise on every field
                m    = 1'($urandom);
                pick = longint'($urandom);
            end
            v = pick[31:0];
            if (m == MODE_PUSH && store_count >= DEPTH)
                full_refusals++;
            transfer_item(m, v, idx, predicted);
            queue_result(predicted);
            n++;
        end
        i_in_valid <= 1'b0;

        // let every result drain, then watch for strays
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers: %0d values stored, %0d rebases, %0d in-range reads",
                 transfers, stored_pushes, rebase_count, good_reads);
        $display("store reached %0d of %0d entries, %0d pushes refused while full",
                 store_count, DEPTH, full_refusals);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/ocs_pkg.sv
design/ocs_cell.sv
design/offset_packed_column_store.sv
verif/tb_offset_packed_column_store.sv
